// ----- rtl/tss_pkg.sv -----
// ----------------------------------------------------------------------------
// tss_pkg: shared types for the tridiagonal system solver
// Controller states and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

  localparam int DataW = 32;
  localparam int IdxW  = 6;
  localparam int ErrW  = 2;
  localparam int WideW = 50;   // Q.16 intermediate values (den, num)

  localparam logic [ErrW-1:0] ERR_NONE   = 2'd0;
  localparam logic [ErrW-1:0] ERR_PIVOT  = 2'd1;
  localparam logic [ErrW-1:0] ERR_ROWS   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDPREV,
    ST_MUL_A,
    ST_DEN,
    ST_NUM,
    ST_CHKDEN,
    ST_DIVA,
    ST_DIVB,
    ST_ENDROW,
    ST_BS_RD,
    ST_BS_MUL,
    ST_BS_ADD,
    ST_BS_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic load;        // capture input word
    logic rd_prev;     // read sweep coefficients of previous row
    logic mul_pa;      // prod = a * alpha_prev
    logic den_cap;     // den from prod and b
    logic mul_pb;      // prod = a * beta_prev
    logic num_cap;     // num from prod and d
    logic zero_pivot;  // den is zero: store zeros, flag error
    logic div_start;   // start divider
    logic div_sel;     // 0: c / den, 1: num / den
    logic cap_alpha;   // take divider result as alpha
    logic cap_beta;    // take divider result as beta
    logic row_done;    // write row, bump count or flag overflow
    logic bs_init;     // start back substitution
    logic bs_rd;       // read coefficients at back-sub index
    logic bs_mul;      // prod = alpha * x
    logic bs_add;      // x = sat(floor(prod) + beta), present word
    logic bs_next;     // step index down
    logic run_end;     // clear count and error latch
  } ctrl_cmd_t;

  typedef struct packed {
    logic full;
    logic den_zero;
    logic div_done;
    logic last;
    logic out_taken;
    logic idx_zero;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/tss_ram.sv -----
// ----------------------------------------------------------------------------
// tss_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tss_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(Depth)-1:0]   waddr,
  input  wire [Width-1:0]           wdata,
  input  wire                       re,
  input  wire [$clog2(Depth)-1:0]   raddr,
  output logic [Width-1:0]          rdata
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tss_ctrl.sv -----
// ----------------------------------------------------------------------------
// tss_ctrl: sequencing state machine
// Steps one row through the forward sweep and runs back substitution.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tss_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  tss_pkg::dp_stat_t     stat,
  output tss_pkg::ctrl_cmd_t    cmd
);

  import tss_pkg::*;

  ctrl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_RDPREV;
      ST_RDPREV: state_nxt = stat.full ? ST_ENDROW : ST_MUL_A;
      ST_MUL_A:  state_nxt = ST_DEN;
      ST_DEN:    state_nxt = ST_NUM;
      ST_NUM:    state_nxt = ST_CHKDEN;
      ST_CHKDEN: state_nxt = stat.den_zero ? ST_ENDROW : ST_DIVA;
      ST_DIVA:   if (stat.div_done) state_nxt = ST_DIVB;
      ST_DIVB:   if (stat.div_done) state_nxt = ST_ENDROW;
      ST_ENDROW: state_nxt = stat.last ? ST_BS_RD : ST_IDLE;
      ST_BS_RD:  state_nxt = ST_BS_MUL;
      ST_BS_MUL: state_nxt = ST_BS_ADD;
      ST_BS_ADD: state_nxt = ST_BS_OUT;
      ST_BS_OUT: begin
        if (stat.out_taken) begin
          state_nxt = stat.idx_zero ? ST_IDLE : ST_BS_RD;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // command decode
  always_comb begin
    cmd      = '0;
    in_stall = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE:   cmd.load = in_valid;
      ST_RDPREV: cmd.rd_prev = 1'b1;
      ST_MUL_A:  cmd.mul_pa = 1'b1;
      ST_DEN: begin
        cmd.den_cap = 1'b1;
        cmd.mul_pb  = 1'b1;
      end
      ST_NUM:    cmd.num_cap = 1'b1;
      ST_CHKDEN: begin
        cmd.zero_pivot = stat.den_zero;
        cmd.div_start  = !stat.den_zero;
        cmd.div_sel    = 1'b0;
      end
      ST_DIVA: begin
        cmd.cap_alpha = stat.div_done;
        cmd.div_start = stat.div_done;
        cmd.div_sel   = 1'b1;
      end
      ST_DIVB:   cmd.cap_beta = stat.div_done;
      ST_ENDROW: begin
        cmd.row_done = 1'b1;
        cmd.bs_init  = stat.last;
      end
      ST_BS_RD:  cmd.bs_rd = 1'b1;
      ST_BS_MUL: cmd.bs_mul = 1'b1;
      ST_BS_ADD: cmd.bs_add = 1'b1;
      ST_BS_OUT: begin
        cmd.bs_next = stat.out_taken && !stat.idx_zero;
        cmd.run_end = stat.out_taken && stat.idx_zero;
      end
      default:   cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/tss_dp.sv -----
// ----------------------------------------------------------------------------
// tss_dp: solver datapath
// Row registers, shared multiplier, bit-serial divider, coefficient RAMs,
// row count, error latch and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tss_dp #(
  parameter int MAX_ROWS = 64
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  tss_pkg::ctrl_cmd_t         cmd,
  output tss_pkg::dp_stat_t          stat,
  input  wire signed [31:0]          in_sub_diag,
  input  wire signed [31:0]          in_main_diag,
  input  wire signed [31:0]          in_super_diag,
  input  wire signed [31:0]          in_rhs,
  input  wire                        in_last_row,
  input  wire                        out_stall,
  output logic                       out_valid,
  output logic signed [31:0]         out_solution,
  output logic [5:0]                 out_row_index,
  output logic                       out_last_result,
  output logic [1:0]                 out_error_code
);

  import tss_pkg::*;

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = $clog2(MAX_ROWS + 1);

  // row registers
  logic signed [DataW-1:0] a_r, b_r, c_r, d_r;
  logic                    last_r;
  logic [CW-1:0]           rows_r;
  logic [ErrW-1:0]         err_r;
  logic signed [63:0]      prod_r;
  logic signed [WideW-1:0] den_r, num_r;
  logic signed [DataW-1:0] alpha_res_r, beta_res_r;
  logic signed [DataW-1:0] x_r;
  logic [AW-1:0]           bs_idx_r;
  logic                    out_valid_r;

  logic                    first_row;
  logic                    full;
  logic [DataW-1:0]        alpha_rd, beta_rd;
  logic [AW-1:0]           rd_addr;

  assign first_row = (rows_r == '0);
  assign full      = (rows_r == CW'(MAX_ROWS));

  // coefficient stores
  assign rd_addr = cmd.bs_rd ? bs_idx_r : AW'(rows_r - 1'b1);

  tss_ram #(.Width(DataW), .Depth(MAX_ROWS)) u_alpha (
    .clk   (clk),
    .we    (cmd.row_done && !full),
    .waddr (rows_r[AW-1:0]),
    .wdata (alpha_res_r),
    .re    (cmd.rd_prev || cmd.bs_rd),
    .raddr (rd_addr),
    .rdata (alpha_rd)
  );

  tss_ram #(.Width(DataW), .Depth(MAX_ROWS)) u_beta (
    .clk   (clk),
    .we    (cmd.row_done && !full),
    .waddr (rows_r[AW-1:0]),
    .wdata (beta_res_r),
    .re    (cmd.rd_prev || cmd.bs_rd),
    .raddr (rd_addr),
    .rdata (beta_rd)
  );

  // input word capture; a is zero on first row, c zero on last row
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r    <= first_row ? '0 : in_sub_diag;
      b_r    <= in_main_diag;
      c_r    <= in_last_row ? '0 : in_super_diag;
      d_r    <= in_rhs;
      last_r <= in_last_row;
    end
  end

  // shared multiplier
  logic signed [DataW-1:0] mul_op1, mul_op2, prev_pa, prev_pb;
  assign prev_pa = first_row ? '0 : $signed(alpha_rd);
  assign prev_pb = first_row ? '0 : $signed(beta_rd);
  assign mul_op1 = cmd.bs_mul ? $signed(alpha_rd) : a_r;
  assign mul_op2 = cmd.bs_mul ? x_r : (cmd.mul_pb ? prev_pb : prev_pa);

  always_ff @(posedge clk) begin
    if (cmd.mul_pa || cmd.mul_pb || cmd.bs_mul) begin
      prod_r <= mul_op1 * mul_op2;
    end
  end

  // den = floor((-a*alpha - b*2^16) / 2^16), num = floor((a*beta - d*2^16) / 2^16)
  logic signed [65:0] den_full, num_full, prod_ext;
  assign prod_ext = {{2{prod_r[63]}}, prod_r};
  assign den_full = -prod_ext - $signed({{18{b_r[31]}}, b_r, 16'h0});
  assign num_full = prod_ext - $signed({{18{d_r[31]}}, d_r, 16'h0});

  always_ff @(posedge clk) begin
    if (cmd.den_cap) den_r <= den_full[65:16];
    if (cmd.num_cap) num_r <= num_full[65:16];
  end

  // bit-serial divider on magnitudes: q = |n|*2^16 / |den|
  logic [WideW:0]          div_rem_r;
  logic [31:0]             div_lo_r;
  logic [WideW-1:0]        div_d_r;
  logic [5:0]              div_cnt_r;
  logic                    div_busy_r, div_neg_r, div_ovf_r;
  logic signed [WideW-1:0] dv_n;
  logic [WideW-1:0]        n_mag, d_mag, n_hi;
  logic [WideW:0]          trial;
  logic                    trial_ge;
  logic                    div_done;
  logic [DataW-1:0]        div_q;

  assign dv_n     = cmd.div_sel ? num_r : WideW'(c_r);
  assign n_mag    = dv_n[WideW-1] ? WideW'(-dv_n) : dv_n;
  assign d_mag    = den_r[WideW-1] ? WideW'(-den_r) : den_r;
  assign n_hi     = {16'h0, n_mag[WideW-1:16]};
  assign trial    = {div_rem_r[WideW-1:0], div_lo_r[31]};
  assign trial_ge = (trial >= {1'b0, div_d_r});
  assign div_done = div_busy_r && (div_cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
    end else if (cmd.div_start) begin
      div_busy_r <= 1'b1;
      div_cnt_r  <= 6'd32;
    end else if (div_done) begin
      div_busy_r <= 1'b0;
    end else if (div_busy_r) begin
      div_cnt_r  <= div_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_rem_r <= {1'b0, n_hi};
      div_lo_r  <= {n_mag[15:0], 16'h0};
      div_d_r   <= d_mag;
      div_neg_r <= dv_n[WideW-1] ^ den_r[WideW-1];
      div_ovf_r <= (n_hi >= d_mag);
    end else if (div_busy_r && (div_cnt_r != '0)) begin
      div_rem_r <= trial_ge ? (trial - {1'b0, div_d_r}) : trial;
      div_lo_r  <= {div_lo_r[30:0], trial_ge};
    end
  end

  // saturate signed quotient
  always_comb begin
    if (div_neg_r) begin
      div_q = (div_ovf_r || (div_lo_r > 32'h8000_0000)) ? 32'h8000_0000 : -div_lo_r;
    end else begin
      div_q = (div_ovf_r || div_lo_r[31]) ? 32'h7fff_ffff : div_lo_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.zero_pivot) begin
      alpha_res_r <= '0;
      beta_res_r  <= '0;
    end else begin
      if (cmd.cap_alpha) alpha_res_r <= $signed(div_q);
      if (cmd.cap_beta)  beta_res_r  <= $signed(div_q);
    end
  end

  // row count and error latch; first error of a run is kept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= '0;
      err_r  <= ERR_NONE;
    end else if (cmd.run_end) begin
      rows_r <= '0;
      err_r  <= ERR_NONE;
    end else begin
      if (cmd.zero_pivot && err_r == ERR_NONE) err_r <= ERR_PIVOT;
      if (cmd.row_done) begin
        if (full) begin
          if (err_r == ERR_NONE) err_r <= ERR_ROWS;
        end else begin
          rows_r <= rows_r + 1'b1;
        end
      end
    end
  end

  // back substitution: x = sat(floor(alpha*x / 2^16) + beta)
  logic signed [48:0] bs_sum;
  logic signed [DataW-1:0] bs_sat;
  assign bs_sum = $signed({prod_r[63], prod_r[63:16]}) + $signed({{17{beta_rd[31]}}, beta_rd});
  always_comb begin
    if (bs_sum > 49'sd2147483647)       bs_sat = 32'sh7fff_ffff;
    else if (bs_sum < -49'sd2147483648) bs_sat = 32'sh8000_0000;
    else                                bs_sat = bs_sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.bs_init) begin
      x_r      <= '0;
      bs_idx_r <= full ? AW'(MAX_ROWS - 1) : rows_r[AW-1:0];
    end else begin
      if (cmd.bs_add)  x_r      <= bs_sat;
      if (cmd.bs_next) bs_idx_r <= bs_idx_r - 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.bs_add) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_solution    = x_r;
  assign out_row_index   = 6'(bs_idx_r);
  assign out_last_result = (bs_idx_r == '0);
  assign out_error_code  = err_r;

  assign stat.full      = full;
  assign stat.den_zero  = (den_r == '0);
  assign stat.div_done  = div_done;
  assign stat.last      = last_r;
  assign stat.out_taken = out_valid_r && !out_stall;
  assign stat.idx_zero  = (bs_idx_r == '0);

endmodule

`default_nettype wire

// ----- rtl/tridiagonal_system_solver_unit.sv -----
// ----------------------------------------------------------------------------
// tridiagonal_system_solver_unit: Thomas solver, Q16.16 fixed point
// Operation: a row is accepted in idle; the block then fetches, multiplies,
//   checks the pivot, runs two bit-serial divisions (alpha, then beta) and
//   writes back; a zero pivot skips the divisions, a full store all but fetch and write-back.
// Throughput: one row at a time; on a last row back substitution then presents
//   one word at a time, each computed only after the previous one is taken.
// Reset: synchronous active-low rst_n clears row count, error code, FSM and
//   valid; coefficient stores are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tridiagonal_system_solver_unit #(
  parameter int MAX_ROWS = 64
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire signed [31:0]  in_sub_diag,
  input  wire signed [31:0]  in_main_diag,
  input  wire signed [31:0]  in_super_diag,
  input  wire signed [31:0]  in_rhs,
  input  wire                in_last_row,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [31:0] out_solution,
  output logic [5:0]         out_row_index,
  output logic               out_last_result,
  output logic [1:0]         out_error_code
);

  import tss_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  tss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  tss_dp #(.MAX_ROWS(MAX_ROWS)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_sub_diag     (in_sub_diag),
    .in_main_diag    (in_main_diag),
    .in_super_diag   (in_super_diag),
    .in_rhs          (in_rhs),
    .in_last_row     (in_last_row),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_solution    (out_solution),
    .out_row_index   (out_row_index),
    .out_last_result (out_last_result),
    .out_error_code  (out_error_code)
  );

`ifndef SYNTHESIS
  // no result pending while ready for a new row
  a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid) else $error("result pending while idle");

  // final word of a run returns the block to idle
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_result) |=> !in_stall)
    else $error("not idle after last word");

  // index stays inside the store
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_row_index) < MAX_ROWS)) else $error("row index out of range");
`endif

endmodule

`default_nettype wire
